// ===== design/stroke_stream_interpolator_assert.svh =====
// Assertion macros shared by the stroke stream interpolator modules.
`ifndef STROKE_STREAM_INTERPOLATOR_ASSERT_SVH
`define STROKE_STREAM_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssi: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssi: next-cycle check failed");
`else
`define SSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ssi_pkg.sv =====
// Shared types and constants of the stroke stream interpolator.
package ssi_pkg;

    // Number of line segments per record; each record gives this many plus one points.
    localparam int INTERP_SEGMENTS = 5;

    localparam int POS_W   = 20;
    localparam int BYTE_W  = 8;
    localparam int SCALE_W = 12;
    localparam int HUE_W   = 8;

    localparam int STEP_W = $clog2(INTERP_SEGMENTS + 1);
    localparam int REM_W  = $clog2(INTERP_SEGMENTS + 1);

    // Reciprocal of the segment count: quotient = (a * RECIP_MULT) >> RECIP_SHIFT,
    // low by at most one for any a below 2**POS_W.
    localparam int RECIP_SHIFT = POS_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'((64'd1 << RECIP_SHIFT) / INTERP_SEGMENTS);

    localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;

    localparam logic [HUE_W-1:0] HUE_STEP = 8'd3;

    // Command queue; depth is a power of two so the pointers wrap on their own.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration register map.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_UP_CODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y      = 3'd5;

    localparam logic signed [BYTE_W-1:0]  RST_PEN_UP_CODE = -8'sd128;
    localparam logic signed [POS_W-1:0]   RST_ORIGIN_X    = 20'sd4608;
    localparam logic signed [POS_W-1:0]   RST_ORIGIN_Y    = 20'sd19200;
    localparam logic [SCALE_W-1:0]        RST_GLYPH_SCALE = 12'd256;
    localparam logic signed [POS_W-1:0]   RST_HOME_X      = 20'sd4608;
    localparam logic signed [POS_W-1:0]   RST_HOME_Y      = 20'sd19200;

    // One classified record from the parser.
    typedef struct packed {
        logic                     line;  // a complete record: draw or move
        logic                     pen;   // 1 for a draw record
        logic signed [BYTE_W-1:0] gx;
        logic signed [BYTE_W-1:0] gy;
        logic                     last;  // glyph ends after this record
    } t_cmd;

    // Geometry registers seen by the back end.
    typedef struct packed {
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
        logic [SCALE_W-1:0]      scale;
        logic signed [POS_W-1:0] home_x;
        logic signed [POS_W-1:0] home_y;
    } t_back_cfg;

endpackage

// ===== design/ssi_front.sv =====
// Byte parser: splits the stroke stream into draw, move and end commands.
module ssi_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [ssi_pkg::BYTE_W-1:0] i_code_byte,
    input  logic                            i_last_byte,
    input  logic signed [ssi_pkg::BYTE_W-1:0] i_pen_up_code,
    input  logic                            i_q_ready,
    output logic                            o_push,
    output ssi_pkg::t_cmd                   o_cmd
);
    import ssi_pkg::*;

    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_DRAW_Y = 2'd1;
    localparam logic [1:0] PH_MOVE_X = 2'd2;
    localparam logic [1:0] PH_MOVE_Y = 2'd3;

    logic [1:0]               r_phase, n_phase;
    logic signed [BYTE_W-1:0] r_held, n_held;
    logic                     accept;
    logic                     line, pen;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        line    = 1'b0;
        pen     = 1'b0;
        case (r_phase)
            PH_START: begin
                if (i_code_byte == i_pen_up_code) begin
                    n_phase = PH_MOVE_X;
                end else begin
                    n_held  = i_code_byte;
                    n_phase = PH_DRAW_Y;
                end
            end
            PH_DRAW_Y: begin
                line    = 1'b1;
                pen     = 1'b1;
                n_phase = PH_START;
            end
            PH_MOVE_X: begin
                n_held  = i_code_byte;
                n_phase = PH_MOVE_Y;
            end
            PH_MOVE_Y: begin
                line    = 1'b1;
                n_phase = PH_START;
            end
            default: begin
                n_phase = PH_START;
            end
        endcase
        // an unfinished record is dropped at the end of the glyph
        if (i_last_byte) begin
            n_phase = PH_START;
        end
    end

    assign o_push    = accept && (line || i_last_byte);
    assign o_cmd.line = line;
    assign o_cmd.pen  = pen;
    assign o_cmd.gx   = r_held;
    assign o_cmd.gy   = i_code_byte;
    assign o_cmd.last = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

// ===== design/ssi_cmd_fifo.sv =====
// Short command queue between the parser and the interpolation back end.
`include "stroke_stream_interpolator_assert.svh"
module ssi_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssi_pkg::t_cmd i_cmd,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssi_pkg::t_cmd o_cmd
);
    import ssi_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_not_full = (r_count != Q_CW'(Q_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_cmd      = r_mem[r_rd];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SSI_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= Q_CW'(Q_DEPTH))
    `SSI_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, o_not_full)

endmodule

// ===== design/ssi_back.sv =====
// Interpolation back end: target, reciprocal divide, point emitter, output register.
`include "stroke_stream_interpolator_assert.svh"
module ssi_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ssi_pkg::t_back_cfg             i_cfg,
    input  logic                           i_q_valid,
    input  ssi_pkg::t_cmd                  i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [ssi_pkg::POS_W-1:0] o_point_x,
    output logic signed [ssi_pkg::POS_W-1:0] o_point_y,
    output logic                           o_pen_down,
    output logic [ssi_pkg::HUE_W-1:0]      o_light_hue,
    output logic                           o_glyph_end
);
    import ssi_pkg::*;

    localparam int PROD_W = POS_W + RECIP_W;

    function automatic logic signed [POS_W-1:0] f_target(
        input logic signed [POS_W-1:0]  org,
        input logic signed [BYTE_W-1:0] g,
        input logic [SCALE_W-1:0]       sc
    );
        logic signed [BYTE_W+SCALE_W:0]   prod;
        logic signed [POS_W+1:0]          sum;
        prod = $signed({{(SCALE_W+1){g[BYTE_W-1]}}, g})
             * $signed({{(BYTE_W+1){1'b0}}, sc});
        sum  = $signed({{2{org[POS_W-1]}}, org})
             + $signed({{(POS_W+1-BYTE_W-SCALE_W){prod[BYTE_W+SCALE_W]}}, prod});
        if (sum > $signed({{2{POS_MAX[POS_W-1]}}, POS_MAX})) begin
            return POS_MAX;
        end else if (sum < $signed({{2{POS_MIN[POS_W-1]}}, POS_MIN})) begin
            return POS_MIN;
        end
        return sum[POS_W-1:0];
    endfunction

    // ---------------- pipeline control ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_e_v, r_ov;
    logic s1_go, s2_go, s3_go, s1_free, s3_free, s2_free, e_free, e_last;
    logic out_take, emit;

    // stage 1: target
    logic                     r_s1_line, r_s1_pen, r_s1_last;
    logic signed [POS_W-1:0]  r_s1_tx, r_s1_ty;
    // position the next record starts from
    logic signed [POS_W-1:0]  r_plan_x, r_plan_y;
    // stage 2: difference and reciprocal product
    logic                     r_s2_line, r_s2_pen, r_s2_last;
    logic signed [POS_W-1:0]  r_s2_sx, r_s2_sy, r_s2_tx, r_s2_ty;
    logic                     r_s2_negx, r_s2_negy;
    logic [POS_W-1:0]         r_s2_ax, r_s2_ay;
    logic [PROD_W-1:0]        r_s2_px, r_s2_py;
    // stage 3: corrected quotient and remainder
    logic                     r_s3_line, r_s3_pen, r_s3_last;
    logic signed [POS_W-1:0]  r_s3_sx, r_s3_sy, r_s3_tx, r_s3_ty;
    logic                     r_s3_negx, r_s3_negy;
    logic [POS_W-1:0]         r_s3_qx, r_s3_qy;
    logic [REM_W-1:0]         r_s3_rx, r_s3_ry;
    // emitter
    logic                     r_e_line, r_e_pen, r_e_end;
    logic signed [POS_W-1:0]  r_e_sx, r_e_sy, r_e_tx, r_e_ty;
    logic                     r_e_negx, r_e_negy;
    logic [POS_W-1:0]         r_e_qx, r_e_qy, r_acc_qx, r_acc_qy;
    logic [REM_W-1:0]         r_e_rx, r_e_ry, r_acc_rx, r_acc_ry;
    logic [STEP_W-1:0]        r_step;
    logic [HUE_W-1:0]         r_hue;
    // output register
    logic signed [POS_W-1:0]  r_o_x, r_o_y;
    logic                     r_o_pen, r_o_end;
    logic [HUE_W-1:0]         r_o_hue;

    logic                     step_last;
    assign step_last = (r_step == STEP_W'(INTERP_SEGMENTS));
    assign out_take  = !r_ov || i_ready;
    assign emit      = r_e_v && out_take;
    assign e_last    = emit && (!r_e_line || (step_last && !r_e_end));
    assign e_free    = !r_e_v || e_last;
    assign s3_go     = r_s3_v && e_free;
    assign s3_free   = !r_s3_v || s3_go;
    assign s2_go     = r_s2_v && s3_free;
    assign s2_free   = !r_s2_v || s2_go;
    assign s1_go     = r_s1_v && s2_free;
    assign s1_free   = !r_s1_v || s1_go;
    assign o_q_pop   = i_q_valid && s1_free;

    // ---------------- stage 2 combinational ----------------
    logic signed [POS_W-1:0] s2_tx, s2_ty;
    logic signed [POS_W:0]   dx, dy;
    logic [POS_W-1:0]        ax, ay;
    assign s2_tx = r_s1_line ? r_s1_tx : r_plan_x;
    assign s2_ty = r_s1_line ? r_s1_ty : r_plan_y;
    assign dx    = $signed({s2_tx[POS_W-1], s2_tx}) - $signed({r_plan_x[POS_W-1], r_plan_x});
    assign dy    = $signed({s2_ty[POS_W-1], s2_ty}) - $signed({r_plan_y[POS_W-1], r_plan_y});
    assign ax    = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ay    = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];

    // ---------------- stage 3 combinational ----------------
    logic [POS_W-1:0] qex, qey, remx, remy;
    assign qex  = r_s2_px[RECIP_SHIFT +: POS_W];
    assign qey  = r_s2_py[RECIP_SHIFT +: POS_W];
    assign remx = r_s2_ax - POS_W'(qex * POS_W'(INTERP_SEGMENTS));
    assign remy = r_s2_ay - POS_W'(qey * POS_W'(INTERP_SEGMENTS));

    // ---------------- emitter combinational ----------------
    logic signed [POS_W+1:0] ptx_w, pty_w;
    logic signed [POS_W-1:0] pt_x, pt_y;
    logic [REM_W:0]          sum_rx, sum_ry;
    logic                    carry_x, carry_y;
    assign ptx_w = $signed({{2{r_e_sx[POS_W-1]}}, r_e_sx})
                 + (r_e_negx ? -$signed({2'b00, r_acc_qx}) : $signed({2'b00, r_acc_qx}));
    assign pty_w = $signed({{2{r_e_sy[POS_W-1]}}, r_e_sy})
                 + (r_e_negy ? -$signed({2'b00, r_acc_qy}) : $signed({2'b00, r_acc_qy}));
    assign pt_x    = ptx_w[POS_W-1:0];
    assign pt_y    = pty_w[POS_W-1:0];
    assign sum_rx  = {1'b0, r_acc_rx} + {1'b0, r_e_rx};
    assign sum_ry  = {1'b0, r_acc_ry} + {1'b0, r_e_ry};
    assign carry_x = (sum_rx >= (REM_W+1)'(INTERP_SEGMENTS));
    assign carry_y = (sum_ry >= (REM_W+1)'(INTERP_SEGMENTS));

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_e_v    <= 1'b0;
            r_ov     <= 1'b0;
            r_plan_x <= RST_HOME_X;
            r_plan_y <= RST_HOME_Y;
            r_hue    <= '0;
        end else begin
            if (s1_free) begin
                r_s1_v <= i_q_valid;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (s3_free) begin
                r_s3_v <= r_s2_v;
            end
            if (e_free) begin
                r_e_v <= r_s3_v;
            end
            if (out_take) begin
                r_ov <= r_e_v;
            end
            if (s1_go) begin
                if (r_s1_last) begin
                    r_plan_x <= i_cfg.home_x;
                    r_plan_y <= i_cfg.home_y;
                end else begin
                    r_plan_x <= s2_tx;
                    r_plan_y <= s2_ty;
                end
            end
            if (emit && r_e_line && r_e_pen) begin
                r_hue <= r_hue + HUE_STEP;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_line <= i_q_cmd.line;
            r_s1_pen  <= i_q_cmd.pen;
            r_s1_last <= i_q_cmd.last;
            r_s1_tx   <= f_target(i_cfg.origin_x, i_q_cmd.gx, i_cfg.scale);
            r_s1_ty   <= f_target(i_cfg.origin_y, i_q_cmd.gy, i_cfg.scale);
        end
        if (s1_go) begin
            r_s2_line <= r_s1_line;
            r_s2_pen  <= r_s1_pen;
            r_s2_last <= r_s1_last;
            r_s2_sx   <= r_plan_x;
            r_s2_sy   <= r_plan_y;
            r_s2_tx   <= s2_tx;
            r_s2_ty   <= s2_ty;
            r_s2_negx <= dx[POS_W];
            r_s2_negy <= dy[POS_W];
            r_s2_ax   <= ax;
            r_s2_ay   <= ay;
            r_s2_px   <= PROD_W'(ax * RECIP_MULT);
            r_s2_py   <= PROD_W'(ay * RECIP_MULT);
        end
        if (s2_go) begin
            r_s3_line <= r_s2_line;
            r_s3_pen  <= r_s2_pen;
            r_s3_last <= r_s2_last;
            r_s3_sx   <= r_s2_sx;
            r_s3_sy   <= r_s2_sy;
            r_s3_tx   <= r_s2_tx;
            r_s3_ty   <= r_s2_ty;
            r_s3_negx <= r_s2_negx;
            r_s3_negy <= r_s2_negy;
            if (remx >= POS_W'(INTERP_SEGMENTS)) begin
                r_s3_qx <= qex + 1'b1;
                r_s3_rx <= REM_W'(remx - POS_W'(INTERP_SEGMENTS));
            end else begin
                r_s3_qx <= qex;
                r_s3_rx <= REM_W'(remx);
            end
            if (remy >= POS_W'(INTERP_SEGMENTS)) begin
                r_s3_qy <= qey + 1'b1;
                r_s3_ry <= REM_W'(remy - POS_W'(INTERP_SEGMENTS));
            end else begin
                r_s3_qy <= qey;
                r_s3_ry <= REM_W'(remy);
            end
        end
        // a new job replaces the bookkeeping of the one just finished;
        // otherwise advance the accumulators one segment per emitted line point
        if (s3_go) begin
            r_e_line <= r_s3_line;
            r_e_pen  <= r_s3_pen;
            r_e_end  <= r_s3_last;
            r_e_sx   <= r_s3_sx;
            r_e_sy   <= r_s3_sy;
            r_e_tx   <= r_s3_tx;
            r_e_ty   <= r_s3_ty;
            r_e_negx <= r_s3_negx;
            r_e_negy <= r_s3_negy;
            r_e_qx   <= r_s3_qx;
            r_e_qy   <= r_s3_qy;
            r_e_rx   <= r_s3_rx;
            r_e_ry   <= r_s3_ry;
            r_step   <= '0;
            r_acc_qx <= '0;
            r_acc_qy <= '0;
            r_acc_rx <= '0;
            r_acc_ry <= '0;
        end else if (emit && r_e_line) begin
            r_step <= r_step + 1'b1;
            if (step_last) begin
                r_e_line <= 1'b0;
            end
            r_acc_qx <= r_acc_qx + r_e_qx + POS_W'(carry_x);
            r_acc_qy <= r_acc_qy + r_e_qy + POS_W'(carry_y);
            r_acc_rx <= carry_x ? REM_W'(sum_rx - (REM_W+1)'(INTERP_SEGMENTS)) : REM_W'(sum_rx);
            r_acc_ry <= carry_y ? REM_W'(sum_ry - (REM_W+1)'(INTERP_SEGMENTS)) : REM_W'(sum_ry);
        end
        if (emit) begin
            if (r_e_line) begin
                r_o_x   <= pt_x;
                r_o_y   <= pt_y;
                r_o_pen <= r_e_pen;
                r_o_hue <= r_e_pen ? r_hue : '0;
                r_o_end <= 1'b0;
            end else begin
                r_o_x   <= r_e_tx;
                r_o_y   <= r_e_ty;
                r_o_pen <= 1'b0;
                r_o_hue <= '0;
                r_o_end <= 1'b1;
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_point_x   = r_o_x;
    assign o_point_y   = r_o_y;
    assign o_pen_down  = r_o_pen;
    assign o_light_hue = r_o_hue;
    assign o_glyph_end = r_o_end;

    `SSI_ASSERT_IMPL(a_last_point_on_target, i_clk, i_rst_n,
        r_e_v && r_e_line && step_last, (pt_x == r_e_tx) && (pt_y == r_e_ty))
    `SSI_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_e_v,
        (r_acc_rx < REM_W'(INTERP_SEGMENTS)) && (r_acc_ry < REM_W'(INTERP_SEGMENTS)))
    `SSI_ASSERT_IMPL(a_end_pen_off, i_clk, i_rst_n, r_ov && r_o_end,
        !r_o_pen && (r_o_hue == '0))

endmodule

// ===== design/stroke_stream_interpolator.sv =====
// Top level of the stroke stream interpolator: configuration registers and block wiring.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  stream    in         i_valid / o_ready    i_code_byte, i_last_byte
//  points    out        o_valid / i_ready    o_point_x, o_point_y, o_pen_down,
//                                            o_light_hue, o_glyph_end
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A byte is taken in the cycle it arrives while the command queue has space; the
// parser holds no more than one byte of a record.
// A complete record passes through the back end pipeline stages (target, reciprocal
// product, quotient correction), overlapped with the emission of the record before.
// The emitter gives one point per cycle while the output accepts: INTERP_SEGMENTS+1
// points per record plus one end transfer per glyph.
// Reset (synchronous, active low) empties the queue and pipeline, loads default
// registers and puts the pen at home. A stalled output holds the emitter, the
// pipeline backs up behind it, and o_ready drops once the queue is full.
module stroke_stream_interpolator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [ssi_pkg::BYTE_W-1:0]      i_code_byte,
    input  logic                                   i_last_byte,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [ssi_pkg::POS_W-1:0]       o_point_x,
    output logic signed [ssi_pkg::POS_W-1:0]       o_point_y,
    output logic                                   o_pen_down,
    output logic [ssi_pkg::HUE_W-1:0]              o_light_hue,
    output logic                                   o_glyph_end,
    input  logic                                   i_cfg_we,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ssi_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import ssi_pkg::*;

    // Configuration registers; to be written only while the block is idle (the block does not enforce this).
    logic signed [BYTE_W-1:0] r_pen_up_code;
    logic signed [POS_W-1:0]  r_origin_x, r_origin_y, r_home_x, r_home_y;
    logic [SCALE_W-1:0]       r_glyph_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_up_code <= RST_PEN_UP_CODE;
            r_origin_x    <= RST_ORIGIN_X;
            r_origin_y    <= RST_ORIGIN_Y;
            r_glyph_scale <= RST_GLYPH_SCALE;
            r_home_x      <= RST_HOME_X;
            r_home_y      <= RST_HOME_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PEN_UP_CODE: r_pen_up_code <= i_cfg_data[BYTE_W-1:0];
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data[POS_W-1:0];
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[POS_W-1:0];
                CFG_GLYPH_SCALE: r_glyph_scale <= i_cfg_data[SCALE_W-1:0];
                CFG_HOME_X:      r_home_x      <= i_cfg_data[POS_W-1:0];
                CFG_HOME_Y:      r_home_y      <= i_cfg_data[POS_W-1:0];
                default:         ; // drop writes beyond the register map
            endcase
        end
    end

    t_back_cfg back_cfg;
    assign back_cfg.origin_x = r_origin_x;
    assign back_cfg.origin_y = r_origin_y;
    assign back_cfg.scale    = r_glyph_scale;
    assign back_cfg.home_x   = r_home_x;
    assign back_cfg.home_y   = r_home_y;

    // Front: classify bytes into commands.
    logic q_not_full, q_push, q_valid, q_pop;
    t_cmd push_cmd, head_cmd;

    ssi_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_byte   (i_code_byte),
        .i_last_byte   (i_last_byte),
        .i_pen_up_code (r_pen_up_code),
        .i_q_ready     (q_not_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    // Queue: decouple parsing from point emission.
    ssi_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (push_cmd),
        .o_not_full (q_not_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_cmd      (head_cmd)
    );

    // Back: compute targets, divide the step, emit the points.
    ssi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_pen_down  (o_pen_down),
        .o_light_hue (o_light_hue),
        .o_glyph_end (o_glyph_end)
    );

endmodule
